// File: hw/rtl/tcvg_pkg.sv
// Shared constants, types and the quarter-wave sine table of the turtle
// command vector generator. No dependencies.
package tcvg_pkg;

    // Table size and position fraction bits
    localparam int SINE_ENTRIES  = 1024;
    localparam int FRACTION_BITS = 8;

    localparam int IDX_W       = $clog2(SINE_ENTRIES);
    localparam int QUARTER     = SINE_ENTRIES / 4;
    localparam int QIDX_W      = IDX_W - 2;
    localparam int DISP_SHIFT  = 23 - FRACTION_BITS;
    localparam int TABLE_PEAK  = 32767;

    // Angle between neighboring quarter table entries, radians
    localparam real QUARTER_STEP = 1.5707963267948966 / real'(QUARTER);

    localparam int POS_W       = 32;
    localparam int ANGLE_W     = 16;
    localparam int STEP_W      = 16;
    localparam int SYM_W       = 8;
    localparam int CFG_INDEX_W = 8;

    // Command bytes
    localparam logic [SYM_W-1:0] CMD_FORWARD = 8'd70;   // 'F'
    localparam logic [SYM_W-1:0] CMD_PLUS    = 8'd43;   // '+'
    localparam logic [SYM_W-1:0] CMD_MINUS   = 8'd45;   // '-'

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TURN_ANGLE  = 8'd1;

    localparam logic [STEP_W-1:0]  STEP_LENGTH_RESET = 16'd256;
    localparam logic [ANGLE_W-1:0] TURN_ANGLE_RESET  = 16'd10923;

    // Sine and cosine of one heading, Q1.15
    typedef struct packed {
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } trig_t;

    typedef logic [14:0] qtab_t [QUARTER];

    // First quadrant magnitudes, round(32767*sin), halves away from zero
    function automatic qtab_t build_quarter();
        qtab_t tab;
        real   ang;
        for (int m = 0; m < QUARTER; m++) begin
            ang    = QUARTER_STEP * real'(m);
            tab[m] = 15'(int'(real'(TABLE_PEAK) * $sin(ang)));
        end
        return tab;
    endfunction

    localparam qtab_t QUARTER_SINE = build_quarter();

    // Full-circle sine from the quarter table by symmetry
    function automatic logic signed [15:0] sine_of(logic [IDX_W-1:0] k);
        logic [1:0]        quad;
        logic [QIDX_W-1:0] m;
        logic [14:0]       mag;
        quad = k[IDX_W-1 -: 2];
        m    = k[QIDX_W-1:0];
        if (quad[0]) begin
            // descending quadrant; a zero offset sits on the peak
            if (m == '0) mag = 15'(TABLE_PEAK);
            else         mag = QUARTER_SINE[QIDX_W'(-m)];
        end else begin
            mag = QUARTER_SINE[m];
        end
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// File: hw/rtl/tcvg_sincos.sv
// Sine and cosine lookup for a 16-bit binary angle.
// Depends on tcvg_pkg (table and trig_t).
module tcvg_sincos
    import tcvg_pkg::*;
(
    input  logic [ANGLE_W-1:0] heading,
    output trig_t              trig
);

    logic [IDX_W-1:0] sin_idx;
    logic [IDX_W-1:0] cos_idx;

    // Table index is the top bits of the angle; cosine leads by a quarter turn
    assign sin_idx = heading[ANGLE_W-1 -: IDX_W];
    assign cos_idx = sin_idx + IDX_W'(QUARTER);

    assign trig.sin_v = sine_of(sin_idx);
    assign trig.cos_v = sine_of(cos_idx);

endmodule

// File: hw/rtl/turtle_command_vector_generator.sv
// Top level of the turtle command vector generator.
// Depends on tcvg_pkg and tcvg_sincos.
//
// Takes one turtle command byte per cycle on the s_ stream and emits one line
// segment on the m_ stream for every 'F'; '+' and '-' turn the heading by
// turn_angle, other bytes are dropped. An item with s_tuser set loads the
// start position and zero heading before its byte is handled. Every item
// is held in the input register, where the sine/cosine table lookup,
// the two step multiplies and the position adds complete against the pen
// state; a segment then sits in the output register until taken. Throughput
// is one item per cycle; it falls only while a segment waits on m_tready and
// the next item is also an 'F'. Configuration writes are always accepted and
// belong between streams.
module turtle_command_vector_generator
    import tcvg_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data,

    // Command stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [71:0]            s_tdata,   // symbol[7:0], start_x[39:8], start_y[71:40]
    input  logic                   s_tuser,   // first

    // Segment stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [127:0]           m_tdata    // seg_x0, seg_y0, seg_x1, seg_y1 (32 each)
);

    logic [STEP_W-1:0]  step_length_reg;
    logic [ANGLE_W-1:0] turn_angle_reg;

    logic               in_vld_reg;
    logic [SYM_W-1:0]   sym_reg;
    logic               first_reg;
    logic [POS_W-1:0]   sx_reg;
    logic [POS_W-1:0]   sy_reg;

    logic [POS_W-1:0]   pen_x_reg, pen_x_next;
    logic [POS_W-1:0]   pen_y_reg, pen_y_next;
    logic [ANGLE_W-1:0] heading_reg, heading_next;

    logic               out_vld_reg;
    logic [POS_W-1:0]   x0_reg, y0_reg, x1_reg, y1_reg;

    logic               is_fwd;
    logic               out_free;
    logic               consume;
    logic [POS_W-1:0]   cur_x, cur_y;
    logic [ANGLE_W-1:0] cur_h;
    trig_t              trig;
    logic signed [32:0] prod_x, prod_y;
    logic [POS_W-1:0]   new_x, new_y;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_length_reg <= STEP_LENGTH_RESET;
            turn_angle_reg  <= TURN_ANGLE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_STEP_LENGTH: step_length_reg <= cfg_data;
                CFG_TURN_ANGLE:  turn_angle_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: an item leaves the input register unless it is a segment
    // with the output register still full
    assign is_fwd   = (sym_reg == CMD_FORWARD);
    assign out_free = !out_vld_reg || m_tready;
    assign consume  = in_vld_reg && (!is_fwd || out_free);
    assign s_tready = !in_vld_reg || consume;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            sym_reg   <= s_tdata[7:0];
            first_reg <= s_tuser;
            sx_reg    <= s_tdata[39:8];
            sy_reg    <= s_tdata[71:40];
        end
    end

    // Pen state as seen by this item, after an optional start load
    assign cur_x = first_reg ? sx_reg : pen_x_reg;
    assign cur_y = first_reg ? sy_reg : pen_y_reg;
    assign cur_h = first_reg ? '0 : heading_reg;

    tcvg_sincos u_sincos (
        .heading (cur_h),
        .trig    (trig)
    );

    // Displacement: step * table entry, floored shift back to Q24.8
    assign prod_x = $signed({1'b0, step_length_reg}) * trig.cos_v;
    assign prod_y = $signed({1'b0, step_length_reg}) * trig.sin_v;
    assign new_x  = cur_x + POS_W'(prod_x >>> DISP_SHIFT);
    assign new_y  = cur_y + POS_W'(prod_y >>> DISP_SHIFT);

    // Next pen state
    always_comb begin
        pen_x_next   = cur_x;
        pen_y_next   = cur_y;
        heading_next = cur_h;
        case (sym_reg)
            CMD_FORWARD: begin
                pen_x_next = new_x;
                pen_y_next = new_y;
            end
            CMD_PLUS:  heading_next = cur_h + turn_angle_reg;
            CMD_MINUS: heading_next = cur_h - turn_angle_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_x_reg   <= '0;
            pen_y_reg   <= '0;
            heading_reg <= '0;
        end else if (consume) begin
            pen_x_reg   <= pen_x_next;
            pen_y_reg   <= pen_y_next;
            heading_reg <= heading_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= consume && is_fwd;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && is_fwd) begin
            x0_reg <= cur_x;
            y0_reg <= cur_y;
            x1_reg <= new_x;
            y1_reg <= new_y;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {y1_reg, x1_reg, y0_reg, x0_reg};

    // A segment moves the pen to its end point
    a_pen_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && is_fwd |=> (pen_x_reg == x1_reg) && (pen_y_reg == y1_reg))
        else $error("pen does not match segment end");

    // A drawn step keeps the heading
    a_fwd_keeps_heading: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && is_fwd && !first_reg |=> $stable(heading_reg))
        else $error("heading changed on forward step");

    // Bytes other than 'F' produce no transfer
    a_no_spurious_seg: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && !is_fwd && out_free |=> !out_vld_reg)
        else $error("segment from non-draw command");

    // The input only stalls on a segment blocked by a full output
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !consume |-> is_fwd && out_vld_reg && !m_tready)
        else $error("input stalled without cause");

endmodule

// File: test/turtle_command_vector_generator_tb.sv
// Self-checking testbench for turtle_command_vector_generator: streams command
// bytes, predicts every line segment and checks it against the m_ stream.
// Depends on tcvg_pkg and the RTL of the block; reads no files.
module turtle_command_vector_generator_tb;
    import tcvg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT    = 400000;
    localparam int  PHASE_ITEMS    = 325;
    localparam int  PHASES         = 6;
    localparam int  DRAIN_CYCLES   = 6;
    localparam int  SHOW_LIMIT     = 10;
    localparam int  DIRECTED_ROWS  = 23;

    // One line segment, laid out as on m_tdata (x0 in the lowest bits)
    typedef struct packed {
        logic [POS_W-1:0] y1;
        logic [POS_W-1:0] x1;
        logic [POS_W-1:0] y0;
        logic [POS_W-1:0] x0;
    } seg_t;

    // One directed command with an optional typed-in segment
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             first;
        logic [POS_W-1:0] sx;
        logic [POS_W-1:0] sy;
        logic             pinned;
        seg_t             seg;
    } cmd_row_t;

    localparam seg_t NO_SEG = '0;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [15:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [71:0]            s_tdata   = '0;   // symbol[7:0], start_x[39:8], start_y[71:40]
    logic                   s_tuser   = 1'b0; // first
    logic                   m_tvalid;
    logic                   m_tready  = 1'b1;
    logic [127:0]           m_tdata;          // seg_x0, seg_y0, seg_x1, seg_y1 (32 each)

    // Predicted pen state and register copies
    logic [POS_W-1:0]   pen_x, pen_y;
    logic [ANGLE_W-1:0] heading;
    logic [STEP_W-1:0]  step_len;
    logic [ANGLE_W-1:0] turn;
    logic signed [15:0] sine_lut [SINE_ENTRIES];

    seg_t pending_segs [$];
    int   mismatch_count = 0;
    int   shown_count    = 0;
    int   segs_checked   = 0;
    int   cmds_sent      = 0;
    int   cfg_writes     = 0;
    int   cycle_count    = 0;
    bit   no_idle        = 1'b0;
    int   hold_left      = 0;

    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        // after reset: heading 0, step 1.0 px -> dx = 255
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b1,
          '{x0: 32'd0, y0: 32'd0, x1: 32'd255, y1: 32'd0}},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b1,
          '{x0: 32'd255, y0: 32'd0, x1: 32'd510, y1: 32'd0}},
        '{CMD_PLUS,    1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{CMD_MINUS,   1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        // heading goes below zero and wraps
        '{CMD_MINUS,   1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        // start load then draw: x wraps past the positive limit
        '{CMD_FORWARD, 1'b1, 32'h7FFF_FF80, 32'h8000_0000, 1'b1,
          '{x0: 32'h7FFF_FF80, y0: 32'h8000_0000, x1: 32'h8000_007F, y1: 32'h8000_0000}},
        // start load then draw: x wraps from -1/256 through zero
        '{CMD_FORWARD, 1'b1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
          '{x0: 32'hFFFF_FFFF, y0: 32'h7FFF_FFFF, x1: 32'h0000_00FE, y1: 32'h7FFF_FFFF}},
        // start load on an ignored byte, then assorted ignored bytes
        '{8'h00,       1'b1, 32'h1234_5678, 32'hEDCB_A987, 1'b0, NO_SEG},
        '{8'hFF,       1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_SEG},
        '{8'h45,       1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},   // 'E'
        '{8'h47,       1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},   // 'G'
        '{8'h2C,       1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},   // ','
        '{8'h2A,       1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},   // '*'
        '{8'h2E,       1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},   // '.'
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        // start load on a turn: turn applies to the cleared heading
        '{CMD_PLUS,    1'b1, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{CMD_MINUS,   1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_SEG},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG},
        '{8'h80,       1'b0, 32'hAAAA_5555, 32'h5555_AAAA, 1'b0, NO_SEG},
        '{CMD_FORWARD, 1'b0, 32'h0, 32'h0, 1'b0, NO_SEG}
    };

    turtle_command_vector_generator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d segments still pending",
                     cycle_count, pending_segs.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Full-circle Q1.15 sine table, built from first-quadrant magnitudes
    initial begin : build_sine
        int qmag [QUARTER+1];
        int quad, m, mag;
        for (int i = 0; i <= QUARTER; i++)
            qmag[i] = int'(32767.0 * $sin(1.5707963267948966 * real'(i) / real'(QUARTER)));
        for (int k = 0; k < SINE_ENTRIES; k++) begin
            quad = k / QUARTER;
            m    = k % QUARTER;
            mag  = (quad % 2 == 1) ? qmag[QUARTER - m] : qmag[m];
            sine_lut[k] = 16'((quad >= 2) ? -mag : mag);
        end
    end

    // step_length * entry, floored to the position fraction
    function automatic logic [POS_W-1:0] step_offset(logic signed [15:0] entry);
        longint prod;
        prod = longint'(step_len) * longint'(entry);
        return POS_W'(prod >>> DISP_SHIFT);
    endfunction

    // Advance the pen for one command; returns 1 when it draws a segment
    function automatic bit trace_command(logic [SYM_W-1:0] sym, logic first,
                                         logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                                         output seg_t seg);
        logic [IDX_W-1:0] si, ci;
        seg = '0;
        if (first) begin
            pen_x   = sx;
            pen_y   = sy;
            heading = '0;
        end
        case (sym)
            CMD_FORWARD: begin
                si     = heading[ANGLE_W-1 -: IDX_W];
                ci     = si + IDX_W'(QUARTER);
                seg.x0 = pen_x;
                seg.y0 = pen_y;
                pen_x  = pen_x + step_offset(sine_lut[ci]);
                pen_y  = pen_y + step_offset(sine_lut[si]);
                seg.x1 = pen_x;
                seg.y1 = pen_y;
                return 1'b1;
            end
            CMD_PLUS:  heading = heading + turn;
            CMD_MINUS: heading = heading - turn;
            default:   ;
        endcase
        return 1'b0;
    endfunction

    // Send one command; the segment it draws is queued at the accepting edge
    task automatic send_cmd(logic [SYM_W-1:0] sym, logic first,
                            logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                            logic pinned, seg_t pinned_seg);
        int   gap;
        seg_t seg;
        gap = no_idle ? 0 : $urandom_range(6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {sy, sx, sym};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        cmds_sent++;
        if (trace_command(sym, first, sx, sy, seg)) begin
            if (pinned)
                seg = pinned_seg;
            pending_segs = {pending_segs, seg};
        end
    endtask

    // Stop the stream and let every expected segment come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Both registers in random order plus one write to an unused index
    task automatic program_regs(logic [STEP_W-1:0] new_step, logic [ANGLE_W-1:0] new_turn);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [15:0]            val [3];
        int                     swap;
        idx[0] = CFG_STEP_LENGTH;  val[0] = new_step;
        idx[1] = CFG_TURN_ANGLE;   val[1] = new_turn;
        idx[2] = CFG_INDEX_W'($urandom_range(255, 2));
        val[2] = 16'($urandom);
        swap   = $urandom_range(2);
        {idx[0], idx[swap]} = {idx[swap], idx[0]};
        {val[0], val[swap]} = {val[swap], val[0]};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            cfg_writes++;
            if (idx[i] == CFG_STEP_LENGTH)
                step_len = val[i];
            else if (idx[i] == CFG_TURN_ANGLE)
                turn = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    // Compare one segment transfer with the oldest expectation
    task automatic check_segment(seg_t got);
        seg_t want;
        if (pending_segs.size() == 0) begin
            mismatch_count++;
            if (shown_count < SHOW_LIMIT) begin
                shown_count++;
                $display("unexpected segment (%h,%h)->(%h,%h)",
                         got.x0, got.y0, got.x1, got.y1);
            end
            return;
        end
        want = pending_segs.pop_front();
        segs_checked++;
        if (got.x0 !== want.x0 || got.y0 !== want.y0 ||
            got.x1 !== want.x1 || got.y1 !== want.y1) begin
            mismatch_count++;
            if (shown_count < SHOW_LIMIT) begin
                shown_count++;
                $display("segment %0d: expected (%h,%h)->(%h,%h) got (%h,%h)->(%h,%h)",
                         segs_checked, want.x0, want.y0, want.x1, want.y1,
                         got.x0, got.y0, got.x1, got.y1);
            end
        end
    endtask

    // Segment sink with random back-pressure after each transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_segment(seg_t'(m_tdata));
                hold_left = no_idle ? 0 : $urandom_range(6);
                if (hold_left > 0) begin
                    m_tready  <= 1'b0;
                    hold_left--;
                end
            end else if (!m_tready) begin
                if (hold_left == 0)
                    m_tready <= 1'b1;
                else
                    hold_left--;
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        logic [SYM_W-1:0]   sym;
        logic               first;
        logic [POS_W-1:0]   sx, sy;
        logic [STEP_W-1:0]  ph_step;
        logic [ANGLE_W-1:0] ph_turn;
        int                 counted, pick;

        pen_x    = '0;
        pen_y    = '0;
        heading  = '0;
        step_len = STEP_LENGTH_RESET;
        turn     = TURN_ANGLE_RESET;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands under the reset register values
        foreach (directed_rows[r])
            send_cmd(directed_rows[r].sym, directed_rows[r].first, directed_rows[r].sx,
                     directed_rows[r].sy, directed_rows[r].pinned, directed_rows[r].seg);
        drain();

        // Random command streams, one register setting per phase
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin ph_step = '0;         ph_turn = '1;          end
                1:       begin ph_step = '1;         ph_turn = '0;          end
                2:       begin ph_step = '1;         ph_turn = 16'h4000;    end
                3:       begin ph_step = 16'd1;      ph_turn = 16'd1;       end
                default: begin ph_step = 16'($urandom); ph_turn = 16'($urandom); end
            endcase
            program_regs(ph_step, ph_turn);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if (counted % 64 == 0)
                    no_idle = ($urandom_range(3) == 0);
                pick  = $urandom_range(99);
                sym   = (pick < 40) ? CMD_FORWARD :
                        (pick < 60) ? CMD_PLUS :
                        (pick < 80) ? CMD_MINUS : SYM_W'($urandom_range(255));
                first = ($urandom_range(15) == 0);
                sx    = $urandom;
                sy    = $urandom;
                // start points close to the wrap boundaries now and then
                if (first && $urandom_range(3) == 0) begin
                    sx = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(65535)
                                           : 32'h8000_0000 + $urandom_range(65535);
                    sy = $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(65535)
                                           : 32'h8000_0000 + $urandom_range(65535);
                end
                send_cmd(sym, first, sx, sy, 1'b0, NO_SEG);
                counted++;
            end
            no_idle = 1'b0;
            drain();
        end

        if (pending_segs.size() != 0)
            mismatch_count += pending_segs.size();
        $display("%0d commands sent, %0d segments checked, %0d register writes",
                 cmds_sent, segs_checked, cfg_writes);
        $display("%0d register settings incl. zero/full step and zero/full/quarter turn",
                 PHASES + 1);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d failing segments", mismatch_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
